@@ design/rrsg_pkg.sv @@
// Package for the rounded-rectangle span generator: widths, command
// record type, register indexes and reset values. No dependencies.
`default_nettype none

package rrsg_pkg;

  localparam int COORD_W   = 13;   // signed rectangle coordinates and sizes
  localparam int RADIN_W   = 8;    // signed requested radius
  localparam int RAD_W     = 5;    // clamped radius, at most 31
  localparam int COLOR_W   = 32;
  localparam int SCR_W     = 12;   // screen size and span origin
  localparam int SPAN_W    = 13;   // span width and height
  localparam int CFG_IDX_W = 1;

  localparam int MAX_RADIUS_DEF  = 31;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

  typedef enum logic [1:0] {
    CMD_EMPTY,
    CMD_SQUARE,
    CMD_ROUND
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic signed [COORD_W-1:0]   x;
    logic signed [COORD_W-1:0]   y;
    logic signed [COORD_W-1:0]   w;
    logic signed [COORD_W-1:0]   h;
    logic        [RAD_W-1:0]     r;
    logic        [COLOR_W-1:0]   color;
  } cmd_t;

endpackage

`default_nettype wire

@@ design/rounded_rect_span_generator_top.sv @@
// Top level of the rounded-rectangle span generator: configuration
// registers, front end, command queue and span sequencer.
// Depends on rrsg_pkg, rrsg_front, rrsg_fifo and rrsg_back.
//
// Usage:
//   Fill commands enter on the in_ channel (valid/ready). Each command is a
//   rectangle, a requested corner radius and a packed pixel value. The block
//   answers with one or more spans on the out_ channel (valid/ready); the
//   final span of every command carries out_last_span.
//   Square corners, or a rectangle with no area, give exactly one span.
//   A rounded command with clamped radius r gives 1 + 2r spans: the middle
//   band, then the top and bottom span of each corner row.
//   Every span is clipped to screen_width x screen_height, set through the
//   cfg_ port (index 0 width, index 1 height); write them only while idle.
// Timing:
//   A command is taken into a short queue in the cycle it arrives, so
//   commands are accepted while earlier ones are still being expanded.
//   The span sequencer handles one command at a time: a single-span
//   command needs one span step, a rounded one a step of the inset search
//   per column plus square, search, top and bottom steps per row. The first
//   span passes through the queue, the command register and the output
//   register. A stalled receiver holds it and halts the sequencer at its
//   next span; the queue keeps taking commands until it is full.
// Reset:
//   rst_n low (synchronous) empties the queue, idles the sequencer, drops
//   out_valid and restores the screen size to 640 x 480.
`default_nettype none

module rounded_rect_span_generator_top import rrsg_pkg::*; #(
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [SCR_W-1:0]          cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_rect_left,
  input  wire logic signed [COORD_W-1:0] in_rect_top,
  input  wire logic signed [COORD_W-1:0] in_rect_width,
  input  wire logic signed [COORD_W-1:0] in_rect_height,
  input  wire logic signed [RADIN_W-1:0] in_corner_radius,
  input  wire logic        [COLOR_W-1:0] in_fill_color,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [SCR_W-1:0]               out_span_x,
  output logic [SCR_W-1:0]               out_span_y,
  output logic [SPAN_W-1:0]              out_span_width,
  output logic [SPAN_W-1:0]              out_span_height,
  output logic [COLOR_W-1:0]             out_span_color,
  output logic                           out_span_empty,
  output logic                           out_last_span
);

  logic [SCR_W-1:0] screen_width_r;
  logic [SCR_W-1:0] screen_height_r;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_in_cmd;
  cmd_t q_head_cmd;

  // Screen size registers; hold their value between writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= SCREEN_WIDTH_RST;
      screen_height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp the radius and classify the command on the way into the queue.
  rrsg_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rect_left     (in_rect_left),
    .in_rect_top      (in_rect_top),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_corner_radius (in_corner_radius),
    .in_fill_color    (in_fill_color),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_in_cmd)
  );

  // Decouple command intake from span output.
  rrsg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head_cmd)
  );

  // Expand each command into clipped spans; emit a span only when the output
  // register can take the next transfer.
  rrsg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head_cmd),
    .q_pop           (q_pop),
    .screen_width    (screen_width_r),
    .screen_height   (screen_height_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_span_x      (out_span_x),
    .out_span_y      (out_span_y),
    .out_span_width  (out_span_width),
    .out_span_height (out_span_height),
    .out_span_color  (out_span_color),
    .out_span_empty  (out_span_empty),
    .out_last_span   (out_last_span)
  );

endmodule

`default_nettype wire

@@ design/rrsg_front.sv @@
// Front end: accepts fill commands, clamps the corner radius and classifies
// each command for the span sequencer. Depends on rrsg_pkg.
`default_nettype none

module rrsg_front import rrsg_pkg::*; #(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_rect_left,
  input  wire logic signed [COORD_W-1:0] in_rect_top,
  input  wire logic signed [COORD_W-1:0] in_rect_width,
  input  wire logic signed [COORD_W-1:0] in_rect_height,
  input  wire logic signed [RADIN_W-1:0] in_corner_radius,
  input  wire logic        [COLOR_W-1:0] in_fill_color,
  input  wire logic                      q_full,
  output logic                           q_push,
  output cmd_t                           q_cmd
);

  localparam logic signed [COORD_W-1:0] MAX_R = COORD_W'(MAX_RADIUS);

  logic signed [COORD_W-1:0] min_side;
  logic signed [COORD_W-1:0] limit;
  logic signed [COORD_W-1:0] r_clamp;
  logic                      no_area;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    no_area  = (in_rect_width <= 0) || (in_rect_height <= 0);
    min_side = (in_rect_width < in_rect_height) ? in_rect_width : in_rect_height;
    limit    = min_side >>> 1;
    r_clamp  = {{(COORD_W-RADIN_W){in_corner_radius[RADIN_W-1]}}, in_corner_radius};
    if (r_clamp > limit) begin
      r_clamp = limit;
    end
    if (r_clamp > MAX_R) begin
      r_clamp = MAX_R;
    end

    q_cmd.x     = in_rect_left;
    q_cmd.y     = in_rect_top;
    q_cmd.w     = in_rect_width;
    q_cmd.h     = in_rect_height;
    q_cmd.color = in_fill_color;
    q_cmd.r     = r_clamp[RAD_W-1:0];
    if (no_area) begin
      q_cmd.kind = CMD_EMPTY;
    end else if (r_clamp <= 0) begin
      q_cmd.kind = CMD_SQUARE;
    end else begin
      q_cmd.kind = CMD_ROUND;
    end
  end

endmodule

`default_nettype wire

@@ design/rrsg_fifo.sv @@
// Short command queue between the front end and the span sequencer.
// Depends on rrsg_pkg for the command record.
`default_nettype none

module rrsg_fifo import rrsg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ design/rrsg_back.sv @@
// Span sequencer: walks one command at a time, searches the corner insets
// row by row, clips each span to the screen and holds it in the output
// register. Depends on rrsg_pkg.
`default_nettype none

module rrsg_back import rrsg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire cmd_t               q_head,
  output logic                    q_pop,
  input  wire logic [SCR_W-1:0]   screen_width,
  input  wire logic [SCR_W-1:0]   screen_height,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [SCR_W-1:0]        out_span_x,
  output logic [SCR_W-1:0]        out_span_y,
  output logic [SPAN_W-1:0]       out_span_width,
  output logic [SPAN_W-1:0]       out_span_height,
  output logic [COLOR_W-1:0]      out_span_color,
  output logic                    out_span_empty,
  output logic                    out_last_span
);

  localparam int CW = 16;  // working width for unclipped span geometry

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_FIRST = 3'd1;
  localparam logic [ST_W-1:0] ST_SQ    = 3'd2;
  localparam logic [ST_W-1:0] ST_SRCH  = 3'd3;
  localparam logic [ST_W-1:0] ST_TOP   = 3'd4;
  localparam logic [ST_W-1:0] ST_BOT   = 3'd5;

  typedef struct packed {
    logic [SCR_W-1:0]  x;
    logic [SCR_W-1:0]  y;
    logic [SPAN_W-1:0] w;
    logic [SPAN_W-1:0] h;
    logic              empty;
  } span_t;

  function automatic logic signed [CW-1:0] ext_c(input logic signed [COORD_W-1:0] v);
    return {{(CW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic span_t clip_span(
    input logic signed [CW-1:0] x,
    input logic signed [CW-1:0] y,
    input logic signed [CW-1:0] w,
    input logic signed [CW-1:0] h,
    input logic [SCR_W-1:0]     sw,
    input logic [SCR_W-1:0]     sh
  );
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cw;
    logic signed [CW-1:0] ch;
    logic signed [CW-1:0] swx;
    logic signed [CW-1:0] shx;
    logic                 e;
    span_t                s;
    cx  = x;
    cy  = y;
    cw  = w;
    ch  = h;
    swx = {{(CW-SCR_W){1'b0}}, sw};
    shx = {{(CW-SCR_W){1'b0}}, sh};
    e   = (w <= 0) || (h <= 0);
    if (!e) begin
      if (cx < 0) begin
        cw = cw + cx;
        cx = '0;
      end
      if (cy < 0) begin
        ch = ch + cy;
        cy = '0;
      end
      if (cx + cw > swx) begin
        cw = swx - cx;
      end
      if (cy + ch > shx) begin
        ch = shx - cy;
      end
      e = (cw <= 0) || (ch <= 0);
    end
    s.x     = e ? '0 : cx[SCR_W-1:0];
    s.y     = e ? '0 : cy[SCR_W-1:0];
    s.w     = e ? '0 : cw[SPAN_W-1:0];
    s.h     = e ? '0 : ch[SPAN_W-1:0];
    s.empty = e;
    return s;
  endfunction

  logic [ST_W-1:0]    state_r;
  cmd_t               cmd_r;
  logic [RAD_W-1:0]   dy_r;
  logic [RAD_W-1:0]   dx_r;
  logic [RAD_W:0]     oym_r;   // |2dy - 2r + 1|
  logic [RAD_W:0]     oxm_r;   // |2(dx-1) - 2r + 1|, the next column to test
  logic [2*RAD_W+1:0] oy2_r;
  logic [2*RAD_W+1:0] r4_r;

  logic                 out_valid_r;
  span_t                span_r;
  logic [COLOR_W-1:0]   color_r;
  logic                 last_r;

  logic                 out_free;
  logic                 emit;
  logic                 row_last;
  logic signed [CW-1:0] sp_x;
  logic signed [CW-1:0] sp_y;
  logic signed [CW-1:0] sp_w;
  logic signed [CW-1:0] sp_h;
  logic                 sp_last;
  logic signed [CW-1:0] r_c;
  logic signed [CW-1:0] dx_c;
  logic signed [CW-1:0] dy_c;
  logic [2*RAD_W+1:0]   ox2;
  logic [2*RAD_W+2:0]   dist2;
  logic                 inside_arc;
  logic [RAD_W:0]       r2;

  assign out_free = !out_valid_r || out_ready;
  assign emit     = out_free &&
                    (state_r == ST_FIRST || state_r == ST_TOP || state_r == ST_BOT);
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign row_last = (dy_r == cmd_r.r - 1'b1);
  assign r2       = {cmd_r.r, 1'b0};

  // Circle test for the candidate column dx-1 against the current row.
  assign ox2        = (2*RAD_W+2)'(oxm_r) * (2*RAD_W+2)'(oxm_r);
  assign dist2      = {1'b0, ox2} + {1'b0, oy2_r};
  assign inside_arc = (dx_r != '0) && (dist2 <= {1'b0, r4_r});

  always_comb begin
    r_c     = {{(CW-RAD_W){1'b0}}, cmd_r.r};
    dx_c    = {{(CW-RAD_W){1'b0}}, dx_r};
    dy_c    = {{(CW-RAD_W){1'b0}}, dy_r};
    sp_x    = '0;
    sp_y    = '0;
    sp_w    = '0;
    sp_h    = '0;
    sp_last = 1'b0;
    if (state_r == ST_FIRST) begin
      unique case (cmd_r.kind)
        CMD_SQUARE: begin
          sp_x    = ext_c(cmd_r.x);
          sp_y    = ext_c(cmd_r.y);
          sp_w    = ext_c(cmd_r.w);
          sp_h    = ext_c(cmd_r.h);
          sp_last = 1'b1;
        end
        CMD_ROUND: begin
          sp_x = ext_c(cmd_r.x);
          sp_y = ext_c(cmd_r.y) + r_c;
          sp_w = ext_c(cmd_r.w);
          sp_h = ext_c(cmd_r.h) - (r_c <<< 1);
        end
        default: begin
          sp_last = 1'b1;
        end
      endcase
    end else begin
      sp_x = ext_c(cmd_r.x) + dx_c;
      sp_w = ext_c(cmd_r.w) - (dx_c <<< 1);
      sp_h = CW'(1);
      if (state_r == ST_BOT) begin
        sp_y    = ext_c(cmd_r.y) + ext_c(cmd_r.h) - CW'(1) - dy_c;
        sp_last = row_last;
      end else begin
        sp_y = ext_c(cmd_r.y) + dy_c;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            state_r <= ST_FIRST;
          end
        end
        ST_FIRST: begin
          if (emit) begin
            state_r <= (cmd_r.kind == CMD_ROUND) ? ST_SQ : ST_IDLE;
          end
        end
        ST_SQ: begin
          state_r <= ST_SRCH;
        end
        ST_SRCH: begin
          if (!inside_arc) begin
            state_r <= ST_TOP;
          end
        end
        ST_TOP: begin
          if (emit) begin
            state_r <= ST_BOT;
          end
        end
        ST_BOT: begin
          if (emit) begin
            state_r <= row_last ? ST_IDLE : ST_SQ;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Command and corner-walk registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r <= q_head;
    end
    if (state_r == ST_FIRST && emit) begin
      dy_r  <= '0;
      dx_r  <= cmd_r.r;
      oym_r <= r2 - 1'b1;
      oxm_r <= (RAD_W+1)'(1);
      r4_r  <= (2*RAD_W+2)'(r2) * (2*RAD_W+2)'(r2);
    end
    if (state_r == ST_SQ) begin
      oy2_r <= (2*RAD_W+2)'(oym_r) * (2*RAD_W+2)'(oym_r);
    end
    if (state_r == ST_SRCH && inside_arc) begin
      dx_r  <= dx_r - 1'b1;
      oxm_r <= oxm_r + (RAD_W+1)'(2);
    end
    if (state_r == ST_BOT && emit && !row_last) begin
      dy_r  <= dy_r + 1'b1;
      oym_r <= oym_r - (RAD_W+1)'(2);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      span_r  <= clip_span(sp_x, sp_y, sp_w, sp_h, screen_width, screen_height);
      color_r <= cmd_r.color;
      last_r  <= sp_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_span_x      = span_r.x;
  assign out_span_y      = span_r.y;
  assign out_span_width  = span_r.w;
  assign out_span_height = span_r.h;
  assign out_span_color  = color_r;
  assign out_span_empty  = span_r.empty;
  assign out_last_span   = last_r;

  a_inset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> dx_r <= cmd_r.r) else $error("corner inset beyond radius");

  a_last_ends_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    emit && sp_last |=> state_r == ST_IDLE) else $error("last span did not end command");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TOP || state_r == ST_BOT) |-> cmd_r.kind == CMD_ROUND && dy_r < cmd_r.r)
    else $error("corner row outside radius");

endmodule

`default_nettype wire
